// ----- hdl/rrq_pkg.sv -----
package rrq_pkg;

   localparam int ThreadIdWidth = 8;
   localparam int SliceWidth    = 16;

   typedef logic [ThreadIdWidth-1:0] thread_type;
   typedef logic [SliceWidth-1:0]    slice_type;

   typedef enum logic [1:0] {
      KIND_PUSH = 2'd0,
      KIND_POP  = 2'd1,
      KIND_TICK = 2'd2,
      KIND_EXIT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_LINK,
      ST_FINISH
   } state_type;

endpackage

// ----- hdl/rrq_ram.sv -----
module rrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/round_robin_ready_queue_top.sv -----
// Push, and pop and tick that read the tables, pass the read and evaluate states (push
// also link); rejected push, empty pop, idle tick and exit go straight to finish.
// Requests are taken only while idle, one item at a time; each table-reading item takes a
// registered table read, then its writes, through one shared decrement/compare unit.
// Reset (synchronous): queue empty, no thread running, all slice counters zero,
// slice_length 1. Valid bits clear the tables at once; there is no clearing pass.
module round_robin_ready_queue_top #(
   parameter int THREAD_COUNT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  rrq_pkg::slice_type    csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  rrq_pkg::thread_type   req_thread_id,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rrq_pkg::thread_type   rsp_popped_thread,
   output logic                  rsp_queue_empty,
   output logic                  rsp_slice_expired,
   output logic                  rsp_push_error
);

   import rrq_pkg::*;

   localparam int Slots     = THREAD_COUNT + 1;
   localparam int SlotWidth = $clog2(Slots);
   localparam int WideWidth = ThreadIdWidth + 1;
   localparam logic [WideWidth-1:0] ThreadLimit = WideWidth'(THREAD_COUNT);

   state_type             state_ff, state_in;
   slice_type             slice_length_ff;
   logic [SlotWidth-1:0]  head_ff, tail_ff, running_ff;
   logic [Slots-1:0]      queued_ff, slice_valid_ff;
   kind_type              kind_ff;
   logic [SlotWidth-1:0]  slot_ff;
   thread_type            res_popped_ff;
   logic                  res_empty_ff, res_expired_ff, res_perr_ff;
   logic                  rsp_valid_ff;
   thread_type            rsp_popped_ff;
   logic                  rsp_empty_ff, rsp_expired_ff, rsp_perr_ff;

   kind_type              req_kind_enum;
   logic [WideWidth-1:0]  req_slot_wide;
   logic [SlotWidth-1:0]  req_slot;
   logic                  req_in_range, push_ok, req_accept, out_free;

   logic                  table_rd_en;
   logic                  next_wr_en;
   logic [SlotWidth-1:0]  next_wr_addr, next_wr_data, next_rd_data;
   logic                  slice_wr_en;
   slice_type             slice_wr_data, slice_rd_data;
   slice_type             slice_cur, slice_dec;
   logic                  slice_zero, slice_ends;

   assign req_kind_enum = kind_type'(req_kind);
   assign req_slot_wide = {1'b0, req_thread_id} + WideWidth'(1);
   assign req_slot      = req_slot_wide[SlotWidth-1:0];
   assign req_in_range  = {1'b0, req_thread_id} < ThreadLimit;
   assign push_ok       = req_in_range && !queued_ff[req_slot];
   assign req_accept    = req_valid && !req_stall;
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   // shared decrement/compare unit on the addressed slice counter
   assign slice_cur  = slice_valid_ff[slot_ff] ? slice_rd_data : '0;
   assign slice_dec  = slice_cur - SliceWidth'(1);
   assign slice_zero = slice_cur == '0;
   assign slice_ends = slice_zero || (slice_dec == '0);

   rrq_ram #(
      .WIDTH(SlotWidth),
      .DEPTH(Slots)
   ) u_next_ram (
      .clock  (clock),
      .wr_en  (next_wr_en),
      .wr_addr(next_wr_addr),
      .wr_data(next_wr_data),
      .rd_en  (table_rd_en),
      .rd_addr(slot_ff),
      .rd_data(next_rd_data)
   );

   rrq_ram #(
      .WIDTH(SliceWidth),
      .DEPTH(Slots)
   ) u_slice_ram (
      .clock  (clock),
      .wr_en  (slice_wr_en),
      .wr_addr(slot_ff),
      .wr_data(slice_wr_data),
      .rd_en  (table_rd_en),
      .rd_addr(slot_ff),
      .rd_data(slice_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_kind_enum)
                  KIND_PUSH: state_in = push_ok ? ST_READ : ST_FINISH;
                  KIND_POP:  state_in = (head_ff != '0) ? ST_READ : ST_FINISH;
                  KIND_TICK: state_in = (running_ff != '0) ? ST_READ : ST_FINISH;
                  KIND_EXIT: state_in = ST_FINISH;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_READ:   state_in = ST_EVAL;
         ST_EVAL:   state_in = (kind_ff == KIND_PUSH) ? ST_LINK : ST_FINISH;
         ST_LINK:   state_in = ST_FINISH;
         ST_FINISH: state_in = out_free ? ST_IDLE : ST_FINISH;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall     = 1'b1;
      table_rd_en   = 1'b0;
      next_wr_en    = 1'b0;
      next_wr_addr  = slot_ff;
      next_wr_data  = '0;
      slice_wr_en   = 1'b0;
      slice_wr_data = slice_length_ff;
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_READ: table_rd_en = 1'b1;
         ST_EVAL: begin
            if (kind_ff == KIND_PUSH) begin
               next_wr_en    = tail_ff != '0;
               next_wr_addr  = tail_ff;
               next_wr_data  = slot_ff;
               slice_wr_en   = slice_zero;
               slice_wr_data = slice_length_ff;
            end else if (kind_ff == KIND_TICK) begin
               slice_wr_en   = !slice_zero;
               slice_wr_data = slice_dec;
            end
         end
         ST_LINK: begin
            next_wr_en   = 1'b1;
            next_wr_addr = slot_ff;
            next_wr_data = '0;
         end
         ST_FINISH: req_stall = 1'b1;
         default:   req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         slice_length_ff <= SliceWidth'(1);
         head_ff         <= '0;
         tail_ff         <= '0;
         running_ff      <= '0;
         queued_ff       <= '0;
         slice_valid_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            slice_length_ff <= csr_wr_data;
         end
         if (req_accept && req_kind_enum == KIND_EXIT &&
             WideWidth'(running_ff) == req_slot_wide) begin
            running_ff <= '0;
         end
         if (state_ff == ST_EVAL) begin
            if (kind_ff == KIND_PUSH) begin
               queued_ff[slot_ff]      <= 1'b1;
               slice_valid_ff[slot_ff] <= 1'b1;
               tail_ff                 <= slot_ff;
               if (tail_ff == '0) begin
                  head_ff <= slot_ff;
               end
            end else if (kind_ff == KIND_POP) begin
               head_ff            <= next_rd_data;
               queued_ff[slot_ff] <= 1'b0;
               running_ff         <= slot_ff;
               if (next_rd_data == '0) begin
                  tail_ff <= '0;
               end
            end
         end
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff        <= req_kind_enum;
         res_popped_ff  <= '0;
         res_empty_ff   <= 1'b0;
         res_expired_ff <= 1'b0;
         res_perr_ff    <= 1'b0;
         unique case (req_kind_enum)
            KIND_PUSH: begin
               slot_ff     <= req_slot;
               res_perr_ff <= !push_ok;
            end
            KIND_POP: begin
               slot_ff      <= head_ff;
               res_empty_ff <= head_ff == '0;
            end
            KIND_TICK: begin
               slot_ff        <= running_ff;
               res_expired_ff <= running_ff == '0;
            end
            KIND_EXIT: slot_ff <= req_slot;
            default:   slot_ff <= req_slot;
         endcase
      end
      if (state_ff == ST_EVAL) begin
         if (kind_ff == KIND_POP) begin
            res_popped_ff <= ThreadIdWidth'(slot_ff) - ThreadIdWidth'(1);
         end else if (kind_ff == KIND_TICK) begin
            res_expired_ff <= slice_ends;
         end
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_popped_ff  <= res_popped_ff;
         rsp_empty_ff   <= res_empty_ff;
         rsp_expired_ff <= res_expired_ff;
         rsp_perr_ff    <= res_perr_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_popped_thread = rsp_popped_ff;
   assign rsp_queue_empty   = rsp_empty_ff;
   assign rsp_slice_expired = rsp_expired_ff;
   assign rsp_push_error    = rsp_perr_ff;

endmodule
